// ===== rtl/core/lsmt_pkg.sv =====
`timescale 1ns / 1ps

package lsmt_pkg;

  localparam int unsigned DOTS_W = 8;
  localparam int unsigned DOT_W = 9;
  localparam int unsigned LINE_W = 8;
  localparam int unsigned MODE_W = 2;

  localparam logic [DOT_W:0]  DOTS_PER_LINE = 10'd456;
  localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
  localparam logic [LINE_W-1:0] LAST_LINE = 8'd153;
  localparam logic [DOT_W-1:0] MODE2_END = 9'd80;
  localparam logic [DOT_W-1:0] MODE3_END = 9'd252;

  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM = 2'd2;
  localparam logic [MODE_W-1:0] MODE_XFER = 2'd3;

  typedef struct packed {
    logic [DOTS_W-1:0] dots;
    logic              display_on;
    logic              hblank_irq_en;
    logic              vblank_irq_en;
    logic              oam_irq_en;
    logic              match_irq_en;
    logic [LINE_W-1:0] compare_line;
  } item_t;

  typedef struct packed {
    logic [DOT_W-1:0]  dot_in_line;
    logic [LINE_W-1:0] line_number;
    logic [MODE_W-1:0] mode_reg;
    logic              match_prev;
  } timing_state_t;

  typedef struct packed {
    logic [LINE_W-1:0] current_line;
    logic [MODE_W-1:0] current_mode;
    logic              match_flag;
    logic              vblank_irq;
    logic              status_irq;
    logic              render_line_req;
    logic              render_frame_req;
  } result_t;

endpackage

// ===== rtl/core/lsmt_if.sv =====
`timescale 1ns / 1ps

interface lsmt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] dots;
  logic       display_on;
  logic       hblank_irq_en;
  logic       vblank_irq_en;
  logic       oam_irq_en;
  logic       match_irq_en;
  logic [7:0] compare_line;

  modport source (output valid, dots, display_on, hblank_irq_en, vblank_irq_en,
                  oam_irq_en, match_irq_en, compare_line, input ready);
  modport sink (input valid, dots, display_on, hblank_irq_en, vblank_irq_en,
                oam_irq_en, match_irq_en, compare_line, output ready);
endinterface

interface lsmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] current_line;
  logic [1:0] current_mode;
  logic       match_flag;
  logic       vblank_irq;
  logic       status_irq;
  logic       render_line_req;
  logic       render_frame_req;

  modport source (output valid, current_line, current_mode, match_flag, vblank_irq,
                  status_irq, render_line_req, render_frame_req, input ready);
  modport sink (input valid, current_line, current_mode, match_flag, vblank_irq,
                status_irq, render_line_req, render_frame_req, output ready);
endinterface

interface lsmt_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/lsmt_step.sv =====
`timescale 1ns / 1ps

module lsmt_step
  import lsmt_pkg::*;
(
  input  item_t         item,
  input  timing_state_t cur,
  input  logic          frame_level_render,
  output timing_state_t nxt,
  output result_t       res
);

  logic [DOT_W:0]    dot_sum;
  logic              crossed;
  logic [DOT_W:0]    dot_wrapped;
  logic [DOT_W-1:0]  new_dot;
  logic [LINE_W-1:0] line_inc;
  logic              wrap;
  logic [LINE_W-1:0] new_line;
  logic [MODE_W-1:0] step_mode;
  logic              mode_irq;
  logic              now_match;

  // At most 455 + 255 dots, so a single subtraction settles the line crossing.
  assign dot_sum     = {1'b0, cur.dot_in_line} + {2'b00, item.dots};
  assign crossed     = dot_sum >= DOTS_PER_LINE;
  assign dot_wrapped = dot_sum - DOTS_PER_LINE;
  assign new_dot     = crossed ? dot_wrapped[DOT_W-1:0] : dot_sum[DOT_W-1:0];
  assign line_inc    = cur.line_number + 8'd1;
  assign wrap        = crossed && (line_inc > LAST_LINE);

  always_comb begin
    if (!crossed) begin
      new_line = cur.line_number;
    end else if (wrap) begin
      new_line = '0;
    end else begin
      new_line = line_inc;
    end
  end

  always_comb begin
    if (new_line >= FIRST_VBLANK_LINE) begin
      step_mode = MODE_VBLANK;
    end else if (new_dot < MODE2_END) begin
      step_mode = MODE_OAM;
    end else if (new_dot < MODE3_END) begin
      step_mode = MODE_XFER;
    end else begin
      step_mode = MODE_HBLANK;
    end
  end

  always_comb begin
    mode_irq = 1'b0;
    if (step_mode != cur.mode_reg) begin
      case (step_mode)
        MODE_HBLANK: mode_irq = item.hblank_irq_en;
        MODE_VBLANK: mode_irq = item.vblank_irq_en;
        MODE_OAM:    mode_irq = item.oam_irq_en;
        default:     mode_irq = 1'b0;
      endcase
    end
  end

  assign now_match = new_line == item.compare_line;

  always_comb begin
    if (!item.display_on) begin
      // Display off clears the timing but leaves the previous match alone.
      nxt.dot_in_line = '0;
      nxt.line_number = '0;
      nxt.mode_reg    = MODE_HBLANK;
      nxt.match_prev  = cur.match_prev;
      res             = '0;
    end else begin
      nxt.dot_in_line      = new_dot;
      nxt.line_number      = new_line;
      nxt.mode_reg         = step_mode;
      nxt.match_prev       = now_match;
      res.current_line     = new_line;
      res.current_mode     = step_mode;
      res.match_flag       = now_match;
      res.vblank_irq       = crossed && (line_inc == FIRST_VBLANK_LINE);
      res.status_irq       = mode_irq || (now_match && !cur.match_prev && item.match_irq_en);
      res.render_line_req  = crossed && (new_line < FIRST_VBLANK_LINE) && !frame_level_render;
      res.render_frame_req = wrap && frame_level_render;
    end
  end

endmodule

// ===== rtl/core/lcd_scanline_mode_timing_core.sv =====
`timescale 1ns / 1ps

// LCD scanline and mode timing. Each input item advances the display timing
// by 0 to 255 dot clocks and yields exactly one result item with the line,
// the mode, the line-compare flag and the interrupt and render requests that
// the step caused. The block takes one item per clock cycle when the result
// side keeps up; an accepted item waits in the input register and its result
// is then captured in the result register, which offers it. That rate is
// set by the single timing state update (dot add, line crossing, mode decode)
// done in the cycle an item leaves the input register. The frame_level_render
// register is written through the configuration channel, which is always
// ready, and should only be changed while no item is pending.

module lcd_scanline_mode_timing_core
  import lsmt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lsmt_cfg_if.sink   cfg,
  lsmt_in_if.sink    in_ch,
  lsmt_out_if.source out_ch
);

  // Configuration register.
  logic frame_level_render;

  // Input register holding one accepted item.
  item_t s1_item;
  logic  s1_valid;

  // Timing state, committed when an item moves into the result register.
  timing_state_t state;
  timing_state_t state_next;

  // Result register.
  result_t res;
  result_t res_next;
  logic    out_valid;

  logic advance;
  logic in_fire;

  // The input register moves on whenever the result register is empty or is
  // being emptied in this cycle, so a waiting result never stops intake of
  // the one item behind it.
  assign advance      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_level_render <= 1'b0;
    end else if (cfg.valid) begin
      frame_level_render <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item.dots          <= in_ch.dots;
      s1_item.display_on    <= in_ch.display_on;
      s1_item.hblank_irq_en <= in_ch.hblank_irq_en;
      s1_item.vblank_irq_en <= in_ch.vblank_irq_en;
      s1_item.oam_irq_en    <= in_ch.oam_irq_en;
      s1_item.match_irq_en  <= in_ch.match_irq_en;
      s1_item.compare_line  <= in_ch.compare_line;
    end
  end

  // All of one step's arithmetic sits between the input register and the
  // result register.
  lsmt_step u_step (
    .item               (s1_item),
    .cur                (state),
    .frame_level_render (frame_level_render),
    .nxt                (state_next),
    .res                (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.current_line     = res.current_line;
  assign out_ch.current_mode     = res.current_mode;
  assign out_ch.match_flag       = res.match_flag;
  assign out_ch.vblank_irq       = res.vblank_irq;
  assign out_ch.status_irq       = res.status_irq;
  assign out_ch.render_line_req  = res.render_line_req;
  assign out_ch.render_frame_req = res.render_frame_req;

endmodule

// ===== verif/lsmt_timing_monitor.sv =====
`timescale 1ns / 1ps

// Watches the three channels of the scanline timing core and keeps its own
// model of the dot/line/mode state. Each accepted item queues the result the
// block must give for it, and each accepted result is checked against the
// oldest queued one.
module lsmt_timing_monitor
  import lsmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lsmt_cfg_if         cfg,
  lsmt_in_if          in_ch,
  lsmt_out_if         out_ch,
  output int unsigned mismatches,
  output int unsigned in_flight
);

  logic [DOT_W:0]    dot_pos;
  logic [LINE_W-1:0] line_no;
  logic [MODE_W-1:0] mode_now;
  logic              match_seen;
  logic              frame_render;
  result_t           queued_timing[$];

  // Moves the timing state on by one item and returns what the block reports.
  function automatic result_t advance_timing(input item_t it);
    result_t           r;
    logic [MODE_W-1:0] next_mode;
    logic              hit;
    r = '0;
    if (!it.display_on) begin
      // The compare history survives a display-off stretch.
      dot_pos = '0;
      line_no = '0;
      mode_now = MODE_HBLANK;
      return r;
    end
    dot_pos = dot_pos + it.dots;
    if (dot_pos >= DOTS_PER_LINE) begin
      dot_pos = dot_pos - DOTS_PER_LINE;
      if (line_no == LAST_LINE) begin
        line_no = '0;
        r.render_frame_req = frame_render;
      end else begin
        line_no = line_no + 1'b1;
      end
      if (line_no == FIRST_VBLANK_LINE) r.vblank_irq = 1'b1;
      if (line_no < FIRST_VBLANK_LINE && !frame_render) r.render_line_req = 1'b1;
    end
    if (line_no >= FIRST_VBLANK_LINE) next_mode = MODE_VBLANK;
    else if (dot_pos < MODE2_END) next_mode = MODE_OAM;
    else if (dot_pos < MODE3_END) next_mode = MODE_XFER;
    else next_mode = MODE_HBLANK;
    if (next_mode != mode_now) begin
      if ((next_mode == MODE_HBLANK && it.hblank_irq_en) ||
          (next_mode == MODE_VBLANK && it.vblank_irq_en) ||
          (next_mode == MODE_OAM && it.oam_irq_en)) r.status_irq = 1'b1;
    end
    mode_now = next_mode;
    hit = (line_no == it.compare_line);
    if (hit && !match_seen && it.match_irq_en) r.status_irq = 1'b1;
    match_seen = hit;
    r.current_line = line_no;
    r.current_mode = mode_now;
    r.match_flag = hit;
    return r;
  endfunction

  task automatic report(input string why, input result_t e, input result_t g);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected line %0d mode %0d match %b vbl %b stat %b rline %b rframe %b,",
               $realtime, why, e.current_line, e.current_mode, e.match_flag, e.vblank_irq,
               e.status_irq, e.render_line_req, e.render_frame_req,
               " got line %0d mode %0d match %b vbl %b stat %b rline %b rframe %b",
               g.current_line, g.current_mode, g.match_flag, g.vblank_irq, g.status_irq,
               g.render_line_req, g.render_frame_req);
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      dot_pos = '0;
      line_no = '0;
      mode_now = MODE_HBLANK;
      match_seen = 1'b0;
      frame_render = 1'b0;
      mismatches = 0;
      queued_timing.delete();
    end else begin
      if (cfg.valid && cfg.ready) frame_render = cfg.data;
      if (out_ch.valid && out_ch.ready) begin
        got = result_t'({out_ch.current_line, out_ch.current_mode, out_ch.match_flag,
                         out_ch.vblank_irq, out_ch.status_irq, out_ch.render_line_req,
                         out_ch.render_frame_req});
        if (queued_timing.size() == 0) begin
          report("result with no item pending", '0, got);
        end else begin
          want = queued_timing.pop_front();
          if (got !== want) report("result mismatch", want, got);
        end
      end
      if (in_ch.valid && in_ch.ready)
        queued_timing.push_back(advance_timing(item_t'({in_ch.dots, in_ch.display_on,
            in_ch.hblank_irq_en, in_ch.vblank_irq_en, in_ch.oam_irq_en,
            in_ch.match_irq_en, in_ch.compare_line})));
    end
    in_flight = queued_timing.size();
  end

endmodule

// ===== verif/lcd_scanline_mode_timing_core_tb.sv =====
`timescale 1ns / 1ps

// Top of the scanline timing bench. This module only makes stimulus and
// gives the verdict; all prediction and comparison lives in the monitor.
module lcd_scanline_mode_timing_core_tb
  import lsmt_pkg::*;
();

  // Generous bound for about 1400 items, even with both sides stalling.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 350;
  localparam int unsigned PHASES = 4;

  logic        clk;
  logic        rst;
  logic        calm;
  logic [7:0]  cmp_hold;
  int unsigned cycles;
  int unsigned mismatches;
  int unsigned in_flight;

  lsmt_cfg_if cfg ();
  lsmt_in_if  in_ch ();
  lsmt_out_if out_ch ();

  lcd_scanline_mode_timing_core DUT (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lsmt_timing_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lcd_scanline_mode_timing_core_tb: done, errors");
      $finish;
    end
  end

  // The result side stalls about a third of the time, except during the calm
  // phase where it takes every result as soon as it is offered.
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 34);
  end

  // Offers one item, with a random number of idle cycles in front of it, and
  // returns at the clock edge that accepts it. Ready is looked at on the
  // falling edge, where it has settled for the coming rising edge. Valid is
  // left high so that a following item can go out back to back.
  task automatic push_item(input item_t it);
    while (!calm && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.dots <= it.dots;
    in_ch.display_on <= it.display_on;
    in_ch.hblank_irq_en <= it.hblank_irq_en;
    in_ch.vblank_irq_en <= it.vblank_irq_en;
    in_ch.oam_irq_en <= it.oam_irq_en;
    in_ch.match_irq_en <= it.match_irq_en;
    in_ch.compare_line <= it.compare_line;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  // Enables are given as {hblank, vblank, oam, match}, the order of item_t.
  task automatic drive_step(input logic [7:0] d, input logic on, input logic [3:0] en,
                            input logic [7:0] cmp);
    push_item(item_t'({d, on, en, cmp}));
  endtask

  // The render mode only changes once every queued result has come back, so
  // no item in the block sees the write halfway. Every item yields a result,
  // so an empty queue means the block is idle.
  task automatic set_render_mode(input logic frame_mode);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (in_flight != 0);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= frame_mode;
    do @(negedge clk); while (!cfg.ready);
    @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Random items lean on large dot counts so that the run sweeps through
  // several whole frames, vertical blank and the wrap to line 0 included.
  // The compare line is held for stretches so the sweeping line can meet it,
  // and now and then it is moved beyond the last line where it never matches.
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) it.dots = 8'($urandom_range(255, 190));
    else if (pick < 92) it.dots = 8'($urandom_range(255, 0));
    else it.dots = 8'($urandom_range(15, 0));
    it.display_on = ($urandom_range(299) != 0);
    it.hblank_irq_en = 1'($urandom_range(1));
    it.vblank_irq_en = 1'($urandom_range(1));
    it.oam_irq_en = 1'($urandom_range(1));
    it.match_irq_en = 1'($urandom_range(1));
    if ($urandom_range(39) == 0) begin
      if ($urandom_range(99) < 85) cmp_hold = 8'($urandom_range(153, 0));
      else cmp_hold = 8'($urandom_range(255, 154));
    end
    it.compare_line = cmp_hold;
    return it;
  endfunction

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    calm = 1'b0;
    cmp_hold = 8'd0;
    in_ch.valid <= 1'b0;
    in_ch.dots <= '0;
    in_ch.display_on <= 1'b0;
    in_ch.hblank_irq_en <= 1'b0;
    in_ch.vblank_irq_en <= 1'b0;
    in_ch.oam_irq_en <= 1'b0;
    in_ch.match_irq_en <= 1'b0;
    in_ch.compare_line <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed opening in per-line render mode. It walks one line by hand:
    // display held off, switched on (object search entry with a match on
    // line 0), into pixel transfer where no status interrupt may fire, into
    // horizontal blank, across to line 1, then compare lines at and past the
    // last line, a display-off in the middle of a line and a switch back on.
    set_render_mode(1'b0);
    drive_step(8'd255, 1'b0, 4'b1111, 8'd0);
    drive_step(8'd0,   1'b1, 4'b1111, 8'd0);
    drive_step(8'd80,  1'b1, 4'b1111, 8'd0);
    drive_step(8'd171, 1'b1, 4'b1111, 8'd0);
    drive_step(8'd1,   1'b1, 4'b1111, 8'd0);
    drive_step(8'd203, 1'b1, 4'b0000, 8'd0);
    drive_step(8'd1,   1'b1, 4'b1111, 8'd0);
    drive_step(8'd255, 1'b1, 4'b0001, 8'd1);
    drive_step(8'd255, 1'b1, 4'b1111, 8'd1);
    drive_step(8'd0,   1'b1, 4'b1111, 8'd2);
    drive_step(8'd128, 1'b1, 4'b1111, 8'd154);
    drive_step(8'd255, 1'b1, 4'b1111, 8'd255);
    drive_step(8'd127, 1'b1, 4'b1111, 8'd153);
    drive_step(8'd64,  1'b0, 4'b1111, 8'd3);
    drive_step(8'd255, 1'b1, 4'b0010, 8'd170);
    drive_step(8'd255, 1'b1, 4'b0000, 8'd85);
    drive_step(8'd0,   1'b1, 4'b1111, 8'd0);
    drive_step(8'd0,   1'b0, 4'b0000, 8'd0);

    // Random phases alternate the render mode, so both settings see vertical
    // blank and the frame wrap. The third phase runs with no idling on
    // either side.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) set_render_mode(p[0]);
      calm = (p == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) push_item(random_item());
    end
    calm = 1'b0;

    // Drain, then leave a few cycles for any stray result to show up.
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (in_flight != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("lcd_scanline_mode_timing_core_tb: done, clean");
    end else begin
      $display("lcd_scanline_mode_timing_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== lcd_scanline_mode_timing_core.f =====
rtl/core/lsmt_pkg.sv
rtl/core/lsmt_if.sv
rtl/core/lsmt_step.sv
rtl/core/lcd_scanline_mode_timing_core.sv
verif/lsmt_timing_monitor.sv
verif/lcd_scanline_mode_timing_core_tb.sv
